### design/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared widths, fixed-point constants and payload types of the sine/cosine
// polynomial core.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int SCP_ANGLE_W = 32;   // Q8.24 input angle
  localparam int SCP_VALUE_W = 32;   // Q2.30 result
  localparam int SCP_A_W     = 41;   // signed angle in Q.32 after the sine offset
  localparam int SCP_M_W     = 40;   // magnitude in Q.32
  localparam int SCP_X_W     = 31;   // folded angle in Q.30
  localparam int SCP_SQ_W    = 62;   // x * x
  localparam int SCP_Z_W     = 32;   // z = x^2 in Q.30, unsigned
  localparam int SCP_T_W     = 34;   // Horner accumulator, signed Q.30
  localparam int SCP_COEF_W  = 32;   // coefficient and multiplicand width
  localparam int SCP_PROD_W  = 65;   // z * t product
  localparam int SCP_FRAC    = 30;   // fraction bits of Q.30

  localparam int SCP_MOD_STEPS = 5;  // quotient bits of the modulo-2*pi reduction
  localparam int SCP_STEPS     = 4;  // Horner steps

  localparam logic [SCP_M_W-1:0] SCP_PI     = 40'h3_243F_6A89;
  localparam logic [SCP_M_W-1:0] SCP_HALFPI = 40'h1_921F_B544;
  localparam logic [SCP_M_W-1:0] SCP_TWOPI  = 40'h6_487E_D512;
  localparam logic [SCP_M_W-1:0] SCP_X_RND  = 40'd2;

  localparam logic [SCP_SQ_W-1:0]   SCP_SQ_RND   = 62'd536870912;
  localparam logic [SCP_PROD_W:0]   SCP_PROD_RND = 66'd536870912;

  localparam logic signed [SCP_T_W-1:0] SCP_ONE   = 34'sd1073741824;
  localparam logic signed [SCP_T_W-1:0] SCP_M_ONE = -34'sd1073741824;

  // Leading coefficient, loaded as the first accumulator value.
  localparam logic signed [SCP_T_W-1:0] SCP_COEF3 = 34'sd26189;

  // Value added after each multiply by z, in Horner order.
  localparam logic signed [SCP_COEF_W-1:0] SCP_ADDEND [SCP_STEPS] = '{
    -32'sd1491080,
    32'sd44739196,
    -32'sd536870909,
    32'sd1073741824
  };

  typedef struct packed {
    logic               neg;
    logic [SCP_X_W-1:0] x;
  } scp_arg_t;

  typedef struct packed {
    logic                      neg;
    logic [SCP_Z_W-1:0]        z;
    logic signed [SCP_T_W-1:0] t;
  } scp_poly_t;

endpackage

### design/scp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_in_if
// Request channel: command (cosine or sine) and a Q8.24 angle.
// ----------------------------------------------------------------------------
interface scp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic signed [31:0] angle;

  modport source (output valid, output command, output angle, input ready);
  modport sink (input valid, input command, input angle, output ready);
endinterface

### design/scp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_out_if
// Response channel: Q2.30 sine or cosine value.
// ----------------------------------------------------------------------------
interface scp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### design/scp_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_reduce
// Argument reduction pipeline: sine offset, magnitude, modulo 2*pi one
// quotient bit per stage, folds at pi and pi/2, and rounding to Q.30.
// ----------------------------------------------------------------------------
module scp_reduce (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic signed [scp_pkg::SCP_ANGLE_W-1:0] angle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output scp_pkg::scp_arg_t                    out_data
);
  import scp_pkg::*;

  localparam int ST_ABS  = 1;
  localparam int ST_MOD0 = ST_ABS + 1;
  localparam int ST_PI   = ST_MOD0 + SCP_MOD_STEPS;
  localparam int ST_HALF = ST_PI + 1;
  localparam int ST_X    = ST_HALF + 1;
  localparam int NST     = ST_X + 1;

  logic [NST-1:0] vld;
  logic [NST:0]   adv;

  logic signed [SCP_A_W-1:0] a_q;
  logic signed [SCP_A_W-1:0] a_neg;
  logic [SCP_M_W-1:0]        m_q [ST_ABS:ST_HALF];
  logic                      ge_pi;
  logic                      ge_half;
  logic                      neg_pi;
  logic                      neg_half;
  logic [SCP_M_W-1:0]        x_sum;
  logic [SCP_X_W-1:0]        x_q;
  logic                      neg_x;

  // A stage advances when it is empty or its successor advances.
  assign adv[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Scale to Q.32 and subtract pi/2 for sine.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_q <= $signed({angle[SCP_ANGLE_W-1], angle, 8'd0})
             - (command ? $signed({1'b0, SCP_HALFPI}) : '0);
    end
  end

  assign a_neg = -a_q;

  always_ff @(posedge clk) begin
    if (adv[ST_ABS]) begin
      m_q[ST_ABS] <= a_q[SCP_A_W-1] ? a_neg[SCP_M_W-1:0] : a_q[SCP_M_W-1:0];
    end
  end

  // Restoring reduction: subtract 2*pi scaled by 16, 8, 4, 2, 1.
  for (genvar i = ST_MOD0; i < ST_PI; i++) begin : g_mod
    localparam logic [SCP_M_W-1:0] SUB = SCP_TWOPI << (ST_PI - 1 - i);
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        m_q[i] <= (m_q[i-1] >= SUB) ? m_q[i-1] - SUB : m_q[i-1];
      end
    end
  end

  assign ge_pi   = m_q[ST_PI-1] >= SCP_PI;
  assign ge_half = m_q[ST_PI] >= SCP_HALFPI;
  assign x_sum   = m_q[ST_HALF] + SCP_X_RND;

  always_ff @(posedge clk) begin
    if (adv[ST_PI]) begin
      m_q[ST_PI] <= ge_pi ? m_q[ST_PI-1] - SCP_PI : m_q[ST_PI-1];
      neg_pi     <= ge_pi;
    end
    if (adv[ST_HALF]) begin
      m_q[ST_HALF] <= ge_half ? SCP_PI - m_q[ST_PI] : m_q[ST_PI];
      neg_half     <= neg_pi ^ ge_half;
    end
    if (adv[ST_X]) begin
      x_q   <= x_sum[SCP_X_W+1:2];
      neg_x <= neg_half;
    end
  end

  assign in_ready     = adv[0];
  assign out_valid    = vld[ST_X];
  assign out_data.x   = x_q;
  assign out_data.neg = neg_x;

`ifndef SYNTHESIS
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_PI-1] |-> m_q[ST_PI-1] < SCP_TWOPI)
    else $error("reduced angle not below 2*pi");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_HALF] |-> m_q[ST_HALF] <= SCP_HALFPI + SCP_M_W'(1))
    else $error("folded angle above pi/2");
`endif

endmodule

### design/scp_horner_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_horner_step
// One Horner step t' = addend + round(z * t / 2^30), split into a multiply
// stage and a round-and-add stage.
// ----------------------------------------------------------------------------
module scp_horner_step (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  scp_pkg::scp_poly_t                     in_data,
  input  logic signed [scp_pkg::SCP_COEF_W-1:0]  addend,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output scp_pkg::scp_poly_t                     out_data
);
  import scp_pkg::*;

  logic                         mul_vld;
  logic                         add_vld;
  logic                         adv_mul;
  logic                         adv_add;
  logic signed [SCP_PROD_W-1:0] prod_next;
  logic signed [SCP_PROD_W-1:0] prod_q;
  logic [SCP_Z_W-1:0]           mul_z;
  logic                         mul_neg;
  logic [SCP_PROD_W:0]          rnd_sum;
  logic [SCP_PROD_W-SCP_FRAC:0] acc_sum;
  scp_poly_t                    res_q;

  assign adv_add  = !add_vld || out_ready;
  assign adv_mul  = !mul_vld || adv_add;
  assign in_ready = adv_mul;

  assign prod_next = $signed({1'b0, in_data.z}) * $signed(in_data.t[SCP_COEF_W-1:0]);

  // Round half away from zero: bias by 2^29, one less for a negative product.
  assign rnd_sum = {prod_q[SCP_PROD_W-1], prod_q} + SCP_PROD_RND
                   - (SCP_PROD_W + 1)'(prod_q[SCP_PROD_W-1]);
  assign acc_sum = rnd_sum[SCP_PROD_W:SCP_FRAC]
                   + {{(SCP_PROD_W - SCP_FRAC + 1 - SCP_COEF_W){addend[SCP_COEF_W-1]}},
                      addend};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      add_vld <= 1'b0;
    end else begin
      if (adv_mul) mul_vld <= in_valid;
      if (adv_add) add_vld <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_mul) begin
      prod_q  <= prod_next;
      mul_z   <= in_data.z;
      mul_neg <= in_data.neg;
    end
    if (adv_add) begin
      res_q.t   <= acc_sum[SCP_T_W-1:0];
      res_q.z   <= mul_z;
      res_q.neg <= mul_neg;
    end
  end

  assign out_valid = add_vld;
  assign out_data  = res_q;

`ifndef SYNTHESIS
  a_mul_hold: assert property (@(posedge clk) disable iff (rst)
    mul_vld && !adv_add |=> mul_vld && $stable(prod_q) && $stable(mul_z))
    else $error("stalled product lost");
`endif

endmodule

### design/sine_cosine_polynomial_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_core
// Fixed-point sine and cosine by an even degree-8 minimax polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   request carries command (0 cosine, 1 sine) and a signed Q8.24 angle in
//   radians; response carries the signed Q2.30 value, clamped to +/-1.
//   One response word per request word, in order.
//   A word passes 21 register stages. Ten stages reduce the argument
//   (scale and sine offset, magnitude, five quotient bits of the
//   modulo-2*pi step, fold at pi, fold at pi/2, rounding to Q.30), two
//   form z = x^2, two per Horner step for four steps, and one clamps and
//   applies the sign.
//   Throughput is one word per cycle while the receiver does not stall;
//   every stage is a register with its own valid bit, so a new word enters each clock while request.ready is high.
//   When the receiver stalls, words collect in empty stages behind the
//   output register and request.ready stays high until the pipeline is full.
//   Synchronous reset clears all valid bits; no word is in flight after it.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_core (
  input logic        clk,
  input logic        rst,
  scp_in_if.sink     request,
  scp_out_if.source  response
);
  import scp_pkg::*;

  logic                 arg_valid;
  logic                 arg_ready;
  scp_arg_t             arg;

  logic                 sq_vld;
  logic                 z_vld;
  logic                 out_vld;
  logic                 adv_sq;
  logic                 adv_z;
  logic                 adv_out;
  logic [SCP_SQ_W-1:0]  sq_q;
  logic                 sq_neg;
  logic [SCP_SQ_W-1:0]  z_sum;
  logic [SCP_Z_W-1:0]   z_q;
  logic                 z_neg;

  logic [SCP_STEPS:0]   poly_vld;
  logic [SCP_STEPS:0]   poly_rdy;
  scp_poly_t            poly [SCP_STEPS+1];

  logic signed [SCP_T_W-1:0]     r;
  logic signed [SCP_T_W-1:0]     clamped;
  logic signed [SCP_T_W-1:0]     clamped_neg;
  logic signed [SCP_VALUE_W-1:0] out_val;

  scp_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .command   (request.command),
    .angle     (request.angle),
    .out_valid (arg_valid),
    .out_ready (arg_ready),
    .out_data  (arg)
  );

  assign adv_z     = !z_vld || poly_rdy[0];
  assign adv_sq    = !sq_vld || adv_z;
  assign arg_ready = adv_sq;
  assign adv_out   = !out_vld || response.ready;

  assign z_sum = sq_q + SCP_SQ_RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld  <= 1'b0;
      z_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (adv_sq)  sq_vld  <= arg_valid;
      if (adv_z)   z_vld   <= sq_vld;
      if (adv_out) out_vld <= poly_vld[SCP_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_sq) begin
      sq_q   <= arg.x * arg.x;
      sq_neg <= arg.neg;
    end
    if (adv_z) begin
      z_q   <= z_sum[SCP_SQ_W-1:SCP_FRAC];
      z_neg <= sq_neg;
    end
  end

  assign poly_vld[0] = z_vld;
  assign poly[0]     = '{neg: z_neg, z: z_q, t: SCP_COEF3};

  for (genvar s = 0; s < SCP_STEPS; s++) begin : g_step
    scp_horner_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (poly_vld[s]),
      .in_ready  (poly_rdy[s]),
      .in_data   (poly[s]),
      .addend    (SCP_ADDEND[s]),
      .out_valid (poly_vld[s+1]),
      .out_ready (poly_rdy[s+1]),
      .out_data  (poly[s+1])
    );
  end

  assign poly_rdy[SCP_STEPS] = adv_out;

  // Saturate to +/-1, then apply the sign from the folds.
  assign r = poly[SCP_STEPS].t;

  always_comb begin
    if (r > SCP_ONE) begin
      clamped = SCP_ONE;
    end else if (r < SCP_M_ONE) begin
      clamped = SCP_M_ONE;
    end else begin
      clamped = r;
    end
  end

  assign clamped_neg = -clamped;

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_val <= poly[SCP_STEPS].neg ? clamped_neg[SCP_VALUE_W-1:0]
                                     : clamped[SCP_VALUE_W-1:0];
    end
  end

  assign response.valid = out_vld;
  assign response.value = out_val;

`ifndef SYNTHESIS
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    response.valid |-> (SCP_T_W'(response.value) <= SCP_ONE
                        && SCP_T_W'(response.value) >= SCP_M_ONE))
    else $error("response value outside +/-1");
`endif

endmodule
